// ===== rtl/cascaded_interrupt_controller_defines.svh =====
// Assertion macros for the cascaded interrupt controller.
`ifndef CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH
`define CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define CIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cic check failed");
`define CIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cic check failed");
`else
`define CIC_ASSERT_SAME(label, ante, cons)
`define CIC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/cic_pkg.sv =====
// Shared types, codes and priority functions for the cascaded interrupt controller.
package cic_pkg;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_ACK    = 2'd3;

    localparam logic [3:0] NONE_BIT  = 4'd8;
    localparam logic [2:0] SPUR_LOW  = 3'd7;

    typedef struct packed {
        logic       wr;
        logic       a0;
        logic [7:0] data;
        logic [7:0] rise;
        logic       take;
        logic [2:0] take_bit;
    } cic_cmd_t;

    typedef struct packed {
        logic [7:0] irr;
        logic [7:0] isr;
        logic [7:0] imr;
        logic [4:0] base;
        logic [7:0] icw3;
        logic       aeoi;
        logic       rsel;
    } cic_stat_t;

    function automatic logic [3:0] lowest_bit(input logic [7:0] v);
        logic [3:0] r;
        r = NONE_BIT;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [3:0] pick(input logic [7:0] req, input logic [7:0] imr,
                                        input logic [7:0] isr);
        logic [3:0] p;
        logic [3:0] s;
        p = lowest_bit(req & ~imr);
        s = lowest_bit(isr);
        return (p < s) ? p : NONE_BIT;
    endfunction

endpackage

// ===== rtl/cic_chip.sv =====
// One interrupt controller chip: IRR, ISR, IMR, init sequence and command decode.
module cic_chip (
    input  logic              aclk,
    input  logic              aresetn,
    input  cic_pkg::cic_cmd_t cmd,
    output cic_pkg::cic_stat_t cur,
    output cic_pkg::cic_stat_t nxt
);
    import cic_pkg::*;

    localparam logic [1:0] PH_READY = 2'd0;
    localparam logic [1:0] PH_ICW2  = 2'd1;
    localparam logic [1:0] PH_ICW3  = 2'd2;
    localparam logic [1:0] PH_ICW4  = 2'd3;

    localparam int ICW1_BIT = 4;
    localparam int OCW3_BIT = 3;
    localparam logic [2:0] EOI_NONSPEC = 3'b001;
    localparam logic [2:0] EOI_SPEC    = 3'b011;

    cic_stat_t  stat_reg, stat_next;
    logic [1:0] phase_reg, phase_next;
    logic       ic4_reg, ic4_next;

    always_comb begin
        stat_next  = stat_reg;
        phase_next = phase_reg;
        ic4_next   = ic4_reg;
        if (cmd.wr) begin
            if (!cmd.a0) begin
                if (cmd.data[ICW1_BIT]) begin
                    stat_next.imr  = 8'h00;
                    stat_next.irr  = 8'h00;
                    stat_next.isr  = 8'h00;
                    stat_next.aeoi = 1'b0;
                    stat_next.rsel = 1'b0;
                    ic4_next       = cmd.data[0];
                    phase_next     = PH_ICW2;
                end else if (cmd.data[OCW3_BIT]) begin
                    if (cmd.data[1]) stat_next.rsel = cmd.data[0];
                end else begin
                    case (cmd.data[7:5])
                        EOI_NONSPEC: stat_next.isr = stat_reg.isr & (stat_reg.isr - 8'd1);
                        EOI_SPEC:    stat_next.isr = stat_reg.isr & ~(8'd1 << cmd.data[2:0]);
                        default: ;
                    endcase
                end
            end else begin
                unique case (phase_reg)
                    PH_ICW2: begin
                        stat_next.base = cmd.data[7:3];
                        phase_next     = PH_ICW3;
                    end
                    PH_ICW3: begin
                        stat_next.icw3 = cmd.data;
                        phase_next     = ic4_reg ? PH_ICW4 : PH_READY;
                    end
                    PH_ICW4: begin
                        stat_next.aeoi = cmd.data[1];
                        phase_next     = PH_READY;
                    end
                    default: stat_next.imr = cmd.data;
                endcase
            end
        end
        stat_next.irr = stat_next.irr | cmd.rise;
        if (cmd.take) begin
            stat_next.irr[cmd.take_bit] = 1'b0;
            if (!stat_reg.aeoi) stat_next.isr[cmd.take_bit] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg.irr  <= 8'h00;
            stat_reg.isr  <= 8'h00;
            stat_reg.imr  <= 8'hFF;
            stat_reg.base <= 5'd0;
            stat_reg.icw3 <= 8'h00;
            stat_reg.aeoi <= 1'b0;
            stat_reg.rsel <= 1'b0;
            phase_reg     <= PH_READY;
            ic4_reg       <= 1'b0;
        end else begin
            stat_reg  <= stat_next;
            phase_reg <= phase_next;
            ic4_reg   <= ic4_next;
        end
    end

    assign cur = stat_reg;
    assign nxt = stat_next;

endmodule

// ===== rtl/cascaded_interrupt_controller.sv =====
// Top level of the cascaded master/slave interrupt controller pair.
// Each input word is registered, then applied to both chips and answered by one result
// word in the next stage, so a word can be taken every cycle while the output is not
// stalled. Its result goes from the input register into the result register, which drives
// the output. The result is formed on the path from the chip registers through the slave
// and master priority encoders into the result register. Opcodes: 0 port read, 1 port
// write, 2 line sample, 3 acknowledge.
`include "cascaded_interrupt_controller_defines.svh"

module cascaded_interrupt_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // port_bit[0], write_data[8:1], request_lines[24:9]
    input  logic [2:0]  s_tuser,   // opcode[1:0], chip_select[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], cpu_interrupt[8], ack_vector[16:9]
    output logic [1:0]  m_tuser    // ack_valid[0], spurious[1]
);
    import cic_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic        cs_reg;
    logic        a0_reg;
    logic [7:0]  data_reg;
    logic [15:0] lines_reg;
    logic [15:0] prev_lines_reg;

    logic        out_valid_reg;
    logic [7:0]  rd_reg, rd_next;
    logic        irq_reg, irq_next;
    logic [7:0]  vec_reg, vec_next;
    logic        ackv_reg, ackv_next;
    logic        spur_reg, spur_next;

    logic        advance;
    logic [15:0] rise;

    cic_cmd_t  mcmd, scmd;
    cic_stat_t mcur, mnxt, scur, snxt;
    cic_stat_t sel;

    logic [3:0]  spick, mpick, spick_n, mpick_n;
    logic [7:0]  mreq, mreq_n;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser[1:0];
            cs_reg    <= s_tuser[2];
            a0_reg    <= s_tdata[0];
            data_reg  <= s_tdata[8:1];
            lines_reg <= s_tdata[24:9];
        end
    end

    assign rise = lines_reg & ~prev_lines_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_lines_reg <= 16'h0000;
        end else if (advance && op_reg == OP_SAMPLE) begin
            prev_lines_reg <= lines_reg;
        end
    end

    // priority on current state for acknowledge
    assign spick = pick(scur.irr, scur.imr, scur.isr);
    assign mreq  = mcur.irr | ((spick != NONE_BIT) ? mcur.icw3 : 8'h00);
    assign mpick = pick(mreq, mcur.imr, mcur.isr);

    always_comb begin
        mcmd = '0;
        scmd = '0;
        vec_next  = 8'h00;
        ackv_next = 1'b0;
        spur_next = 1'b0;
        mcmd.a0   = a0_reg;
        mcmd.data = data_reg;
        scmd.a0   = a0_reg;
        scmd.data = data_reg;
        if (advance) begin
            case (op_reg)
                OP_WRITE: begin
                    mcmd.wr = !cs_reg;
                    scmd.wr = cs_reg;
                end
                OP_SAMPLE: begin
                    mcmd.rise = rise[7:0];
                    scmd.rise = rise[15:8];
                end
                OP_ACK: begin
                    ackv_next = 1'b1;
                    if (mpick == NONE_BIT) begin
                        spur_next = 1'b1;
                        vec_next  = {mcur.base, SPUR_LOW};
                    end else begin
                        mcmd.take     = 1'b1;
                        mcmd.take_bit = mpick[2:0];
                        if (mcur.icw3[mpick[2:0]]) begin
                            if (spick == NONE_BIT) begin
                                spur_next = 1'b1;
                                vec_next  = {scur.base, SPUR_LOW};
                            end else begin
                                scmd.take     = 1'b1;
                                scmd.take_bit = spick[2:0];
                                vec_next      = {scur.base, spick[2:0]};
                            end
                        end else begin
                            vec_next = {mcur.base, mpick[2:0]};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    cic_chip u_master (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mcmd),
        .cur     (mcur),
        .nxt     (mnxt)
    );

    cic_chip u_slave (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (scmd),
        .cur     (scur),
        .nxt     (snxt)
    );

    // interrupt line as it stands after this word
    assign spick_n  = pick(snxt.irr, snxt.imr, snxt.isr);
    assign mreq_n   = mnxt.irr | ((spick_n != NONE_BIT) ? mnxt.icw3 : 8'h00);
    assign mpick_n  = pick(mreq_n, mnxt.imr, mnxt.isr);
    assign irq_next = (mpick_n != NONE_BIT);

    assign sel = cs_reg ? scur : mcur;

    always_comb begin
        rd_next = 8'h00;
        if (op_reg == OP_READ) begin
            if (a0_reg) rd_next = sel.imr;
            else        rd_next = sel.rsel ? sel.isr : sel.irr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg   <= rd_next;
            irq_reg  <= irq_next;
            vec_reg  <= vec_next;
            ackv_reg <= ackv_next;
            spur_reg <= spur_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, vec_reg, irq_reg, rd_reg};
    assign m_tuser  = {spur_reg, ackv_reg};

    `CIC_ASSERT_NEXT(a_ack_answered, advance && op_reg == OP_ACK, out_valid_reg && ackv_reg)
    `CIC_ASSERT_NEXT(a_word_held, in_valid_reg && !advance, in_valid_reg)
    `CIC_ASSERT_SAME(a_spur_is_ack, out_valid_reg && spur_reg, ackv_reg)
    `CIC_ASSERT_SAME(a_one_take, mcmd.take, advance && op_reg == OP_ACK)

endmodule
